@@ rtl/b64lw_pkg.sv @@
`timescale 1ns / 1ps
// Package for the base64 encoder with line wrap: payload types, group entry,
// character constants and the six-bit alphabet function. No dependencies.
package b64lw_pkg;

  localparam logic [7:0] WrapThresholdReset = 8'd72;
  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [7:0] CharCr  = 8'd13;
  localparam logic [7:0] CharLf  = 8'd10;
  localparam logic [7:0] CharPad = 8'd61;   // '='
  localparam logic [7:0] CharPlus  = 8'd43; // '+'
  localparam logic [7:0] CharSlash = 8'd47; // '/'
  localparam logic [7:0] CharUpperA = 8'd65;
  localparam logic [7:0] CharLowerA = 8'd97;
  localparam logic [7:0] CharZero   = 8'd48;

  localparam logic [5:0] NumUpper = 6'd26;
  localparam logic [5:0] NumAlpha = 6'd52;
  localparam logic [5:0] NumAlnum = 6'd62;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_of_message;
  } out_t;

  // one encoded group waiting for the back end
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic            crlf;
    logic            last;
  } grp_t;

  function automatic logic [7:0] sixbit_char(input logic [5:0] v);
    logic [7:0] ch;
    if (v < NumUpper) begin
      ch = CharUpperA + {2'b00, v};
    end else if (v < NumAlpha) begin
      ch = CharLowerA + {2'b00, v - NumUpper};
    end else if (v < NumAlnum) begin
      ch = CharZero + {2'b00, v - NumAlpha};
    end else if (v == NumAlnum) begin
      ch = CharPlus;
    end else begin
      ch = CharSlash;
    end
    return ch;
  endfunction

endpackage

@@ rtl/base64_encoder_line_wrap.sv @@
`timescale 1ns / 1ps
// Top level of the base64 encoder with CR LF line wrapping.
// Depends on b64lw_pkg, b64lw_front, b64lw_queue and b64lw_back.
//
//   channel | signals                        | carries
//   --------+--------------------------------+----------------------------
//   in      | in_valid_i, in_ready_o, in_i   | one raw byte, last flag
//   out     | out_valid_o, out_ready_i, out_o| one character, message end
//   cfg     | cfg_we_i, cfg_data_i           | wrap threshold, no wait
//
// A group of three bytes gives four to six characters, one per cycle from the
// output register while the receiver is ready.
// The output character stream sets the rate; the group queue lets the input
// run ahead by QueueDepth groups. Reset clears all state and sets the
// threshold to 72. Either side may stall without losing items.
module base64_encoder_line_wrap #(
  parameter int unsigned QueueDepth = b64lw_pkg::QueueDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [7:0]       cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  b64lw_pkg::in_t   in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output b64lw_pkg::out_t  out_o
);
  import b64lw_pkg::*;

  grp_t grp_push, grp_head;
  logic push, pop, q_full, q_valid;

  b64lw_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .grp_o      (grp_push)
  );

  b64lw_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (grp_push),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .rdata_o (grp_head)
  );

  b64lw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .grp_i       (grp_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

@@ rtl/b64lw_front.sv @@
`timescale 1ns / 1ps
// Front end: collects bytes into groups, encodes them, tracks the line count
// and the wrap threshold. Depends on b64lw_pkg.
module b64lw_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [7:0]       cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  b64lw_pkg::in_t   in_i,
  input  logic             q_full_i,
  output logic             push_o,
  output b64lw_pkg::grp_t  grp_o
);
  import b64lw_pkg::*;

  logic [7:0] thr_q;
  logic [7:0] held0_q, held0_d, held1_q, held1_d;
  logic [1:0] fill_q, fill_d;
  logic [7:0] line_q, line_d;

  logic       accept, emit, full_grp, crlf;
  logic [7:0] b0, b1, b2;
  logic [8:0] sum;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full_grp   = (fill_q == 2'd2);
  assign emit       = in_i.is_last || full_grp;
  assign push_o     = accept && emit;

  always_comb begin
    b0   = (fill_q == 2'd0) ? in_i.data_byte : held0_q;
    b1   = (fill_q == 2'd1) ? in_i.data_byte : (full_grp ? held1_q : 8'd0);
    b2   = full_grp ? in_i.data_byte : 8'd0;
    sum  = {1'b0, line_q} + 9'd4;
    crlf = full_grp ? (sum > {1'b0, thr_q}) : (line_q > thr_q);

    grp_o.chars[0] = sixbit_char(b0[7:2]);
    grp_o.chars[1] = sixbit_char({b0[1:0], b1[7:4]});
    grp_o.chars[2] = (fill_q == 2'd0) ? CharPad : sixbit_char({b1[3:0], b2[7:6]});
    grp_o.chars[3] = full_grp ? sixbit_char(b2[5:0]) : CharPad;
    grp_o.crlf     = crlf;
    grp_o.last     = in_i.is_last;

    held0_d = held0_q;
    held1_d = held1_q;
    fill_d  = fill_q;
    line_d  = line_q;
    if (accept) begin
      if (!emit) begin
        if (fill_q == 2'd0) begin
          held0_d = in_i.data_byte;
        end else begin
          held1_d = in_i.data_byte;
        end
        fill_d = fill_q + 2'd1;
      end else begin
        held0_d = 8'd0;
        held1_d = 8'd0;
        fill_d  = 2'd0;
        if (crlf || in_i.is_last) begin
          line_d = 8'd0;
        end else if (full_grp) begin
          line_d = sum[7:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= WrapThresholdReset;
      held0_q <= 8'd0;
      held1_q <= 8'd0;
      fill_q  <= 2'd0;
      line_q  <= 8'd0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_data_i;
      end
      held0_q <= held0_d;
      held1_q <= held1_d;
      fill_q  <= fill_d;
      line_q  <= line_d;
    end
  end

endmodule

@@ rtl/b64lw_queue.sv @@
`timescale 1ns / 1ps
// Short queue of encoded groups between front and back end.
// Depends on b64lw_pkg.
module b64lw_queue #(
  parameter int unsigned Depth = b64lw_pkg::QueueDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  b64lw_pkg::grp_t  wdata_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output b64lw_pkg::grp_t  rdata_o
);
  import b64lw_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  grp_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ rtl/b64lw_back.sv @@
`timescale 1ns / 1ps
// Back end: walks one queued group character by character into the output
// register, adding CR LF where flagged. Depends on b64lw_pkg.
module b64lw_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  b64lw_pkg::grp_t  grp_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output b64lw_pkg::out_t  out_o
);
  import b64lw_pkg::*;

  logic [2:0] idx_q;
  logic       out_valid_q;
  out_t       out_q;
  logic       load, final_char;
  logic [7:0] ch;

  assign load        = q_valid_i && (!out_valid_q || out_ready_i);
  assign final_char  = grp_i.crlf ? (idx_q == 3'd5) : (idx_q == 3'd3);
  assign pop_o       = load && final_char;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    case (idx_q)
      3'd0:    ch = grp_i.chars[0];
      3'd1:    ch = grp_i.chars[1];
      3'd2:    ch = grp_i.chars[2];
      3'd3:    ch = grp_i.chars[3];
      3'd4:    ch = CharCr;
      default: ch = CharLf;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.out_char        <= ch;
      out_q.last_of_message <= grp_i.last && final_char;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= final_char ? 3'd0 : idx_q + 3'd1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

@@ tb/sv/base64_encoder_line_wrap_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for base64_encoder_line_wrap: directed and random byte
// streams, a running encoder model and an in-order character scoreboard.
// Depends on b64lw_pkg and the RTL top level; needs no files.
module base64_encoder_line_wrap_tb;
  import b64lw_pkg::*;

  localparam int unsigned SettleCycles = 16;
  localparam int unsigned LongHold = 120;

  typedef struct {
    in_t         item;
    int unsigned gap;
    bit          drain;
  } byte_req_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [7:0] cfg_data_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  in_t        in_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  out_t       out_o;

  byte_req_t byte_q[$];
  out_t      char_q[$];

  // encoder model state
  logic [7:0]  thresh = WrapThresholdReset;
  logic [7:0]  held[2];
  int unsigned fill = 0;
  logic [7:0]  line_cnt = '0;

  int unsigned n_bytes = 0, n_msgs = 0, n_chars = 0, n_breaks = 0, n_writes = 0;
  int unsigned n_errors = 0;
  int unsigned gap_max = 8, gap_left = 0, stall_left = 0, hold_left = 0;
  int unsigned n_holds = 0;
  bit          rx_calm = 1'b0;

  base64_encoder_line_wrap i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [7:0] b64_char(logic [5:0] v);
    string abc;
    abc = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    return abc[v];
  endfunction

  function automatic void flag(string msg);
    if (n_errors < 10) $display("%s", msg);
    n_errors++;
  endfunction

  function automatic void encode_byte(in_t it);
    logic [23:0] grp;
    logic [8:0]  sum;
    int unsigned cnt, k;
    bit          brk;
    out_t        c;
    out_t        chars[$];
    n_bytes++;
    brk = 1'b0;
    if (fill < 2 && !it.is_last) begin
      held[fill] = it.data_byte;
      fill++;
      return;
    end
    cnt = fill + 1;
    case (fill)
      0:       grp = {it.data_byte, 16'h0000};
      1:       grp = {held[0], it.data_byte, 8'h00};
      default: grp = {held[0], held[1], it.data_byte};
    endcase
    c.last_of_message = 1'b0;
    for (k = 0; k < 4; k++) begin
      c.out_char = (k > cnt) ? CharPad : b64_char(grp[23 - 6 * k -: 6]);
      chars.push_back(c);
    end
    // only a full group moves the line count; a padded one can still break
    if (cnt == 3) begin
      sum = {1'b0, line_cnt} + 9'd4;
      if (sum > {1'b0, thresh}) begin
        line_cnt = '0;
        brk = 1'b1;
      end else begin
        line_cnt = sum[7:0];
      end
    end else if (line_cnt > thresh) begin
      line_cnt = '0;
      brk = 1'b1;
    end
    if (brk) begin
      c.out_char = CharCr;
      chars.push_back(c);
      c.out_char = CharLf;
      chars.push_back(c);
      n_breaks++;
    end
    held[0] = '0;
    held[1] = '0;
    fill = 0;
    if (it.is_last) begin
      chars[chars.size() - 1].last_of_message = 1'b1;
      line_cnt = '0;
      n_msgs++;
    end
    foreach (chars[j]) char_q.push_back(chars[j]);
  endfunction

  // sender
  always @(posedge clk_i or negedge rst_ni) begin : drive
    logic      v_nxt;
    in_t       d_nxt;
    byte_req_t r;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_i <= '0;
      gap_left = 0;
    end else begin
      v_nxt = in_valid_i;
      d_nxt = in_i;
      if (in_valid_i && in_ready_o) begin
        encode_byte(in_i);
        v_nxt = 1'b0;
      end
      if (!v_nxt) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (byte_q.size() > 0 && !(byte_q[0].drain && char_q.size() != 0)) begin
          r = byte_q.pop_front();
          d_nxt = r.item;
          v_nxt = 1'b1;
          gap_left = r.gap;
        end
      end
      in_valid_i <= v_nxt;
      in_i <= d_nxt;
    end
  end

  // receiver and scoreboard
  always @(posedge clk_i or negedge rst_ni) begin : receive
    out_t exp_c;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        n_chars++;
        if (char_q.size() == 0) begin
          flag($sformatf("mismatch: unexpected char 0x%02h last %0b",
                         out_o.out_char, out_o.last_of_message));
        end else begin
          exp_c = char_q.pop_front();
          if (out_o.out_char !== exp_c.out_char ||
              out_o.last_of_message !== exp_c.last_of_message)
            flag($sformatf("mismatch at char %0d: expected 0x%02h last %0b, got 0x%02h last %0b",
                           n_chars, exp_c.out_char, exp_c.last_of_message,
                           out_o.out_char, out_o.last_of_message));
        end
        if (n_chars % 40 == 0) rx_calm = ($urandom_range(0, 2) == 0);
        stall_left = rx_calm ? 0 : $urandom_range(0, 8);
        // long hold only while plenty of bytes are still waiting to go in
        if (n_holds < 2 && n_chars >= 100 + 150 * n_holds && byte_q.size() > 16) begin
          hold_left = LongHold;
          n_holds++;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic queue_byte(logic [7:0] b, bit last, bit drain);
    byte_req_t r;
    r.item.data_byte = b;
    r.item.is_last = last;
    r.gap = $urandom_range(0, gap_max);
    r.drain = drain;
    byte_q.push_back(r);
  endtask

  task automatic queue_message(int unsigned len);
    int unsigned k;
    gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
    for (k = 0; k < len; k++)
      queue_byte(8'($urandom), k == len - 1, k == 0 && $urandom_range(0, 5) == 0);
  endtask

  task automatic wait_idle();
    int unsigned quiet;
    quiet = 0;
    while (quiet < SettleCycles) begin
      @(posedge clk_i);
      quiet = (byte_q.size() == 0 && !in_valid_i && char_q.size() == 0) ? quiet + 1 : 0;
    end
  endtask

  task automatic set_threshold(logic [7:0] v);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    thresh = v;
    n_writes++;
  endtask

  initial begin : stimulus
    logic [7:0]  phase_thr[6];
    int unsigned p, k, budget, len;
    held[0] = '0;
    held[1] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset threshold; all-zero, all-one, one and two byte tails
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b1, 1'b0);
    queue_byte(8'hff, 1'b0, 1'b0);
    queue_byte(8'hff, 1'b0, 1'b0);
    queue_byte(8'hff, 1'b1, 1'b0);
    queue_byte(8'h80, 1'b1, 1'b0);
    queue_byte(8'hfb, 1'b0, 1'b0);
    queue_byte(8'hff, 1'b1, 1'b0);
    // threshold lowered mid-message so the padded tail breaks the line
    for (k = 0; k < 9; k++) queue_byte(8'($urandom), 1'b0, 1'b0);
    set_threshold(8'd8);
    queue_byte(8'($urandom), 1'b1, 1'b0);
    // zero threshold: every full group ends its line
    set_threshold(8'd0);
    for (k = 0; k < 6; k++) queue_byte(8'($urandom), k == 5, 1'b0);

    phase_thr = '{8'd4, 8'd255, 8'd248, 8'($urandom), 8'd72, 8'($urandom_range(4, 248))};
    for (p = 0; p < 6; p++) begin
      set_threshold(phase_thr[p]);
      if (phase_thr[p] == 8'd255) begin
        // long enough to push the line count past 255
        gap_max = 2;
        for (k = 0; k < 195; k++) queue_byte(8'($urandom), k == 194, k == 100);
      end else begin
        budget = 0;
        while (budget < 20) begin
          len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
          queue_message(len);
          budget += len;
        end
        // leave a group open across the next threshold write
        if ($urandom_range(0, 1) == 1) queue_byte(8'($urandom), 1'b0, 1'b0);
      end
    end
    queue_message(5);
    wait_idle();

    $display("Encoded %0d messages from %0d bytes into %0d checked characters, %0d line breaks.",
             n_msgs, n_bytes, n_chars, n_breaks);
    $display("%0d threshold writes from 0 to 255, with long output holds and input drains.",
             n_writes);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
